@@ hw/rtl/rpm_pkg.sv @@
// Shared types and constants for the reference picture marking block.
// Holds slot mark codes, command codes, register indexes and field widths.
// No dependencies.
package rpm_pkg;

    localparam int NUM_SLOTS_DEF = 17;
    localparam int FN_W          = 16;
    localparam int PN_W          = FN_W + 2;
    localparam int LI_W          = 5;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 2;

    typedef logic [1:0] mark_t;
    localparam mark_t MARK_UNUSED = 2'd0;
    localparam mark_t MARK_SHORT  = 2'd1;
    localparam mark_t MARK_LONG   = 2'd2;

    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_IDR   = 3'd1;
    localparam logic [2:0] MODE_SLIDE = 3'd2;
    localparam logic [2:0] MODE_ADAPT = 3'd3;
    localparam logic [2:0] MODE_MMCO  = 3'd4;

    localparam logic [2:0] OP_UNMARK_SHORT = 3'd1;
    localparam logic [2:0] OP_UNMARK_LONG  = 3'd2;
    localparam logic [2:0] OP_SHORT_TO_LT  = 3'd3;
    localparam logic [2:0] OP_MAX_LONG     = 3'd4;
    localparam logic [2:0] OP_CLEAR_ALL    = 3'd5;
    localparam logic [2:0] OP_CURR_LONG    = 3'd6;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [1:0] STATUS_NO_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_REF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FN_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_USE = 2'd2;

    localparam logic [LI_W-1:0] LI_NONE = 5'h1f;

endpackage

@@ hw/rtl/rpm_picnum.sv @@
// Shared picture number unit: wraps one slot's frame number and compares it.
// Depends on rpm_pkg.
module rpm_picnum
(
    input  logic [rpm_pkg::FN_W-1:0]        slot_fn,
    input  logic [rpm_pkg::FN_W-1:0]        cur_fn,
    input  logic [rpm_pkg::CFG_W-1:0]       fn_bits,
    input  logic signed [rpm_pkg::PN_W-1:0] pic_x,
    input  logic signed [rpm_pkg::PN_W-1:0] best,
    output logic signed [rpm_pkg::PN_W-1:0] value,
    output logic                            eq,
    output logic                            lt
);

    logic [rpm_pkg::CFG_W-1:0]  bits_c;
    logic [rpm_pkg::FN_W:0]     max_fn;
    logic [rpm_pkg::FN_W-1:0]   mask;
    logic [rpm_pkg::FN_W-1:0]   fn_m;
    logic [rpm_pkg::FN_W-1:0]   cur_m;

    always_comb
    begin
        if (fn_bits < 5'd4)
        begin
            bits_c = 5'd4;
        end
        else if (fn_bits > 5'd16)
        begin
            bits_c = 5'd16;
        end
        else
        begin
            bits_c = fn_bits;
        end
        max_fn = (rpm_pkg::FN_W+1)'(1) << bits_c;
        mask   = rpm_pkg::FN_W'(max_fn - (rpm_pkg::FN_W+1)'(1));
        fn_m   = slot_fn & mask;
        cur_m  = cur_fn & mask;
        if (fn_m > cur_m)
        begin
            value = $signed({2'b00, fn_m}) - $signed({1'b0, max_fn});
        end
        else
        begin
            value = $signed({2'b00, fn_m});
        end
        eq = (value == pic_x);
        lt = (value < best);
    end

endmodule

@@ hw/rtl/h264_reference_picture_marking.sv @@
// Top level of the reference picture marking block: slot table and sequencer.
// Depends on rpm_pkg and rpm_picnum.
//
//  channel | signals                       | direction
//  in      | in_valid, in_stall, fields    | command beat into the block
//  out     | out_valid, out_stall, fields  | one result beat per command
//  cfg     | cfg_we, cfg_index, cfg_data   | register writes, no read-back
//
// Each command walks the slot table one slot a cycle through the shared picture
// number unit, then takes a finishing step and a counting walk over all slots.
// Operation 3 adds a walk, and each sliding window eviction adds a finishing
// step and a walk. in_stall is high while a command runs.
// Reset empties the table at once. A stalled result holds the block at its end.
module h264_reference_picture_marking
#(
    parameter int NUM_SLOTS = rpm_pkg::NUM_SLOTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        mode,
    input  logic [15:0]                       frame_id,
    input  logic                              long_term_flag,
    input  logic                              base_ref_flag,
    input  logic [2:0]                        mmco_op,
    input  logic [15:0]                       pic_num_delta,
    input  logic [3:0]                        long_pic_num,
    input  logic [3:0]                        long_frame_index,
    input  logic [4:0]                        max_long_plus1,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [4:0]                        current_slot,
    output logic [4:0]                        short_count,
    output logic [4:0]                        long_count,
    output logic signed [4:0]                 max_long_index
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int XW = (CW > SW ? CW : SW) > 5 ? (CW > SW ? CW : SW) : 5;
    localparam int FW = rpm_pkg::FN_W;
    localparam int PW = rpm_pkg::PN_W;
    localparam int LW = rpm_pkg::LI_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    // slot table
    rpm_pkg::mark_t  mark_reg [NUM_SLOTS];
    logic            base_reg [NUM_SLOTS];
    logic [FW-1:0]   fn_reg   [NUM_SLOTS];
    logic [LW-1:0]   li_reg   [NUM_SLOTS];

    logic [1:0]      state_reg, state_next;
    logic [SW-1:0]   active_reg, active_next;
    logic [FW-1:0]   cur_reg, cur_next;
    logic [LW-1:0]   limit_reg, limit_next;
    logic [4:0]      cfg_maxref_reg, cfg_fnbits_reg, cfg_slots_reg;

    logic [2:0]      mode_reg, op_reg;
    logic            ltf_reg, bflag_reg;
    logic [3:0]      lpn_reg, lfi_reg;
    logic [LW-1:0]   lim4_reg;
    logic [FW-1:0]   fnum_reg;
    logic signed [PW-1:0] picx_reg;

    logic [SW-1:0]   cnt_reg, cnt_next;
    logic            phase_reg, phase_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [SW-1:0]   pick_reg, pick_next;
    logic            pickv_reg, pickv_next;
    logic signed [PW-1:0] best_reg, best_next;
    logic [1:0]      stat_reg, stat_next;
    logic [CW-1:0]   ns_reg, ns_next, nl_reg, nl_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      o_status_reg, o_status_next;
    logic [4:0]      o_slot_reg, o_slot_next, o_ns_reg, o_ns_next, o_nl_reg, o_nl_next;
    logic [4:0]      o_lim_reg, o_lim_next;

    // single write port into the table
    logic            wr_mark, wr_fn, wr_rest;
    logic [SW-1:0]   wr_idx;
    rpm_pkg::mark_t  wr_mark_d;
    logic [LW-1:0]   wr_li_d;

    logic            accept, last, other, hit;
    rpm_pkg::mark_t  m;
    logic signed [PW-1:0] pn_val;
    logic            pn_eq, pn_lt;
    logic [4:0]      maxr;
    logic [LW-1:0]   lim4_in;

    rpm_picnum u_picnum
    (
        .slot_fn (fn_reg[cnt_reg]),
        .cur_fn  (cur_reg),
        .fn_bits (cfg_fnbits_reg),
        .pic_x   (picx_reg),
        .best    (best_reg),
        .value   (pn_val),
        .eq      (pn_eq),
        .lt      (pn_lt)
    );

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign m        = mark_reg[cnt_reg];
    assign last     = (cnt_reg == SW'(NUM_SLOTS - 1));
    assign other    = (cnt_reg != active_reg);
    assign maxr     = (cfg_maxref_reg == 5'd0) ? 5'd1 : cfg_maxref_reg;
    assign lim4_in  = (max_long_plus1 > 5'd16) ? 5'd15 : (max_long_plus1 - 5'd1);

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        cur_next    = cur_reg;
        limit_next  = limit_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        used_next   = used_reg;
        pick_next   = pick_reg;
        pickv_next  = pickv_reg;
        best_next   = best_reg;
        stat_next   = stat_reg;
        ns_next     = ns_reg;
        nl_next     = nl_reg;
        wr_mark     = 1'b0;
        wr_fn       = 1'b0;
        wr_rest     = 1'b0;
        wr_idx      = cnt_reg;
        wr_mark_d   = rpm_pkg::MARK_UNUSED;
        wr_li_d     = rpm_pkg::LI_NONE;
        hit         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        o_status_next  = o_status_reg;
        o_slot_next    = o_slot_reg;
        o_ns_next      = o_ns_reg;
        o_nl_next      = o_nl_reg;
        o_lim_next     = o_lim_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    used_next  = '0;
                    pickv_next = 1'b0;
                    stat_next  = (mode == rpm_pkg::MODE_ALLOC) ? rpm_pkg::STATUS_NO_SLOT
                                                               : rpm_pkg::STATUS_OK;
                end
            end
            ST_SCAN:
            begin
                case (mode_reg)
                    rpm_pkg::MODE_ALLOC:
                    begin
                        if ((XW'(cnt_reg) < XW'(cfg_slots_reg)) && m == rpm_pkg::MARK_UNUSED)
                        begin
                            wr_fn       = 1'b1;
                            active_next = cnt_reg;
                            cur_next    = fnum_reg;
                            stat_next   = rpm_pkg::STATUS_OK;
                            hit         = 1'b1;
                        end
                    end
                    rpm_pkg::MODE_IDR:
                    begin
                        wr_mark = other;
                    end
                    rpm_pkg::MODE_SLIDE:
                    begin
                        if (other && m != rpm_pkg::MARK_UNUSED)
                        begin
                            used_next = used_reg + CW'(1);
                            if (m == rpm_pkg::MARK_SHORT && (!pickv_reg || pn_lt))
                            begin
                                pick_next  = cnt_reg;
                                best_next  = pn_val;
                                pickv_next = 1'b1;
                            end
                        end
                    end
                    rpm_pkg::MODE_MMCO:
                    begin
                        case (op_reg)
                            rpm_pkg::OP_UNMARK_SHORT:
                            begin
                                hit = other && m == rpm_pkg::MARK_SHORT && pn_eq;
                                wr_mark = hit;
                            end
                            rpm_pkg::OP_UNMARK_LONG:
                            begin
                                hit = other && m == rpm_pkg::MARK_LONG
                                      && li_reg[cnt_reg] == {1'b0, lpn_reg};
                                wr_mark = hit;
                            end
                            rpm_pkg::OP_SHORT_TO_LT:
                            begin
                                if (!phase_reg)
                                begin
                                    hit = other && m == rpm_pkg::MARK_LONG
                                          && li_reg[cnt_reg] == {1'b0, lfi_reg};
                                    wr_mark = hit;
                                end
                                else
                                begin
                                    hit = other && m == rpm_pkg::MARK_SHORT && pn_eq;
                                    wr_mark   = hit;
                                    wr_rest   = hit;
                                    wr_mark_d = rpm_pkg::MARK_LONG;
                                    wr_li_d   = {1'b0, lfi_reg};
                                end
                            end
                            rpm_pkg::OP_MAX_LONG:
                            begin
                                wr_mark = other && m == rpm_pkg::MARK_LONG
                                          && ($signed(li_reg[cnt_reg]) > $signed(lim4_reg));
                            end
                            rpm_pkg::OP_CLEAR_ALL:
                            begin
                                wr_mark = other;
                            end
                            rpm_pkg::OP_CURR_LONG:
                            begin
                                hit = other && m == rpm_pkg::MARK_LONG
                                      && li_reg[cnt_reg] == {1'b0, lfi_reg};
                                wr_mark = hit;
                            end
                            default:
                            begin
                                hit = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        hit = 1'b0;
                    end
                endcase
                if (hit || last)
                begin
                    cnt_next = '0;
                    if (mode_reg == rpm_pkg::MODE_MMCO && op_reg == rpm_pkg::OP_SHORT_TO_LT
                        && !phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            ST_FIN:
            begin
                state_next = ST_COUNT;
                cnt_next   = '0;
                ns_next    = '0;
                nl_next    = '0;
                wr_idx     = active_reg;
                case (mode_reg)
                    rpm_pkg::MODE_IDR:
                    begin
                        wr_mark = 1'b1;
                        wr_rest = 1'b1;
                        if (ltf_reg)
                        begin
                            wr_mark_d  = rpm_pkg::MARK_LONG;
                            wr_li_d    = '0;
                            limit_next = '0;
                        end
                        else
                        begin
                            wr_mark_d  = rpm_pkg::MARK_SHORT;
                            limit_next = rpm_pkg::LI_NONE;
                        end
                    end
                    rpm_pkg::MODE_SLIDE:
                    begin
                        if (XW'(used_reg) >= XW'(maxr) && pickv_reg)
                        begin
                            // Evict the oldest short-term frame and walk again.
                            wr_idx     = pick_reg;
                            wr_mark    = 1'b1;
                            state_next = ST_SCAN;
                            used_next  = '0;
                            pickv_next = 1'b0;
                        end
                        else
                        begin
                            if (XW'(used_reg) >= XW'(maxr))
                            begin
                                stat_next = rpm_pkg::STATUS_NO_EVICT;
                            end
                            wr_mark   = 1'b1;
                            wr_rest   = 1'b1;
                            wr_mark_d = rpm_pkg::MARK_SHORT;
                        end
                    end
                    rpm_pkg::MODE_ADAPT:
                    begin
                        wr_mark   = 1'b1;
                        wr_rest   = 1'b1;
                        wr_mark_d = rpm_pkg::MARK_SHORT;
                    end
                    rpm_pkg::MODE_MMCO:
                    begin
                        case (op_reg)
                            rpm_pkg::OP_MAX_LONG:
                            begin
                                limit_next = lim4_reg;
                            end
                            rpm_pkg::OP_CLEAR_ALL:
                            begin
                                limit_next = rpm_pkg::LI_NONE;
                            end
                            rpm_pkg::OP_CURR_LONG:
                            begin
                                wr_mark   = 1'b1;
                                wr_rest   = 1'b1;
                                wr_mark_d = rpm_pkg::MARK_LONG;
                                wr_li_d   = {1'b0, lfi_reg};
                            end
                            default:
                            begin
                                wr_mark = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        wr_mark = 1'b0;
                    end
                endcase
            end
            ST_COUNT:
            begin
                if (m == rpm_pkg::MARK_SHORT)
                begin
                    ns_next = ns_reg + CW'(1);
                end
                else if (m == rpm_pkg::MARK_LONG)
                begin
                    nl_next = nl_reg + CW'(1);
                end
                if (!last)
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
                else if (!(out_valid_reg && out_stall))
                begin
                    // The result beat leaves only once the previous one is taken.
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    o_status_next  = stat_reg;
                    o_slot_next    = 5'(active_reg);
                    o_ns_next      = 5'(ns_next);
                    o_nl_next      = 5'(nl_next);
                    o_lim_next     = limit_reg;
                end
                else
                begin
                    ns_next = ns_reg;
                    nl_next = nl_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                mark_reg[i] <= rpm_pkg::MARK_UNUSED;
                base_reg[i] <= 1'b0;
                fn_reg[i]   <= '0;
                li_reg[i]   <= rpm_pkg::LI_NONE;
            end
        end
        else
        begin
            if (wr_mark)
            begin
                mark_reg[wr_idx] <= wr_mark_d;
            end
            if (wr_rest)
            begin
                li_reg[wr_idx]   <= wr_li_d;
                base_reg[wr_idx] <= bflag_reg;
            end
            if (wr_fn)
            begin
                fn_reg[wr_idx] <= fnum_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            cur_reg        <= '0;
            limit_reg      <= rpm_pkg::LI_NONE;
            cfg_maxref_reg <= 5'd16;
            cfg_fnbits_reg <= 5'd16;
            cfg_slots_reg  <= 5'd17;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            phase_reg      <= 1'b0;
            used_reg       <= '0;
            pickv_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cur_reg       <= cur_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            used_reg      <= used_next;
            pickv_reg     <= pickv_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rpm_pkg::REG_MAX_REF:   cfg_maxref_reg <= cfg_data;
                    rpm_pkg::REG_FN_BITS:   cfg_fnbits_reg <= cfg_data;
                    rpm_pkg::REG_SLOTS_USE: cfg_slots_reg  <= cfg_data;
                    default:                cfg_slots_reg  <= cfg_slots_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            op_reg    <= mmco_op;
            ltf_reg   <= long_term_flag;
            bflag_reg <= base_ref_flag;
            lpn_reg   <= long_pic_num;
            lfi_reg   <= long_frame_index;
            lim4_reg  <= lim4_in;
            fnum_reg  <= frame_id;
            picx_reg  <= $signed({2'b00, cur_reg}) - $signed({2'b00, pic_num_delta})
                         - PW'(1);
        end
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        stat_reg     <= stat_next;
        ns_reg       <= ns_next;
        nl_reg       <= nl_next;
        o_status_reg <= o_status_next;
        o_slot_reg   <= o_slot_next;
        o_ns_reg     <= o_ns_next;
        o_nl_reg     <= o_nl_next;
        o_lim_reg    <= o_lim_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign current_slot   = o_slot_reg;
    assign short_count    = o_ns_reg;
    assign long_count     = o_nl_reg;
    assign max_long_index = $signed(o_lim_reg);

endmodule
